[hw/rtl/sorted_key_table_search_assert.svh]
// assertion macros for the sorted key table search block
// expects clk and rst_n in the scope where a macro is used
`ifndef SORTED_KEY_TABLE_SEARCH_ASSERT_SVH
`define SORTED_KEY_TABLE_SEARCH_ASSERT_SVH

// same-cycle implication
`define SKTS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define SKTS_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hw/rtl/skts_pkg.sv]
// shared constants and types for the sorted key table search block
// no dependencies
package skts_pkg;

  localparam int DEF_TABLE_DEPTH = 64;
  localparam int DEF_KEY_BYTES   = 8;

  localparam int KEY_W    = 64;
  localparam int IDX_W    = 6;
  localparam int CMD_W    = 2;
  localparam int STATUS_W = 2;

  typedef enum logic [CMD_W-1:0] {
    CMD_INSERT     = 2'd0,
    CMD_LIN_SEARCH = 2'd1,
    CMD_BIN_SEARCH = 2'd2,
    CMD_LIST       = 2'd3
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_DONE      = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_FULL      = 2'd2,
    ST_EMPTY     = 2'd3
  } status_t;

endpackage

[hw/rtl/skts_in_if.sv]
// request channel interface for the sorted key table search block
// depends on skts_pkg
interface skts_in_if;
  import skts_pkg::*;

  logic             valid;
  logic             ready;
  logic [CMD_W-1:0] cmd;
  logic [KEY_W-1:0] key;

  modport source (output valid, output cmd, output key, input ready);
  modport sink (input valid, input cmd, input key, output ready);
endinterface

[hw/rtl/skts_out_if.sv]
// result channel interface for the sorted key table search block
// depends on skts_pkg
interface skts_out_if;
  import skts_pkg::*;

  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [IDX_W-1:0]    index;
  logic [KEY_W-1:0]    entry_key;
  logic                last;

  modport source (output valid, output status, output index, output entry_key,
                  output last, input ready);
  modport sink (input valid, input status, input index, input entry_key,
                input last, output ready);
endinterface

[hw/rtl/skts_key_mem.sv]
// key storage: one write port, one read port, registered read data
// depends on skts_pkg
module skts_key_mem #(
  parameter int WORDS = 64,
  parameter int AW    = 6
) (
  input  logic                    clk,
  input  logic                    wr_en,
  input  logic [AW-1:0]           wr_addr,
  input  logic [skts_pkg::KEY_W-1:0] wr_data,
  input  logic [AW-1:0]           rd_addr,
  output logic [skts_pkg::KEY_W-1:0] rd_data
);
  import skts_pkg::*;

  logic [KEY_W-1:0] key_mem_r [WORDS];
  logic [KEY_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      key_mem_r[wr_addr] <= wr_data;
    end
    rd_data_r <= key_mem_r[rd_addr];
  end

  assign rd_data = rd_data_r;
endmodule

[hw/rtl/sorted_key_table_search.sv]
// sorted key table: insert, linear search, binary search and listing
// depends on skts_pkg, skts_in_if, skts_out_if, skts_key_mem and the assert header
//
// usage
// - in_chan carries one request: cmd and key; key bits above 8*KEY_BYTES are ignored
// - out_chan carries results: status, index, entry_key and last
// - insert, linear search and binary search give one result; list gives one
//   result per stored key in ascending order (one result if the table is empty)
// - requests are taken one at a time; in_chan.ready is high only while the
//   sequencer is idle, and a result waiting in the output register does not
//   block the next request
// - insert moves each larger key up one slot (none into an empty or a full
//   table), linear search reads entries from slot 0 up to the hit or through
//   all entries on a miss, binary search reads and compares one probe at a
//   time, and list gives one result per cycle while the receiver does not stall;
//   the key memory has one read and one write port, each used once per cycle
// - reset clears the entry count and the output valid; key memory contents
//   are not cleared, no entry above the count is ever used
// - when the receiver stalls, the output register holds its result and the
//   list walk waits on the same entry
`include "sorted_key_table_search_assert.svh"

module sorted_key_table_search #(
  parameter int TABLE_DEPTH = skts_pkg::DEF_TABLE_DEPTH,
  parameter int KEY_BYTES   = skts_pkg::DEF_KEY_BYTES
) (
  input logic      clk,
  input logic      rst_n,
  skts_in_if.sink  in_chan,
  skts_out_if.source out_chan
);
  import skts_pkg::*;

  // address and count widths
  localparam int AW    = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int WORDS = 1 << AW;
  localparam int CW    = $clog2(TABLE_DEPTH + 1);

  // only the low key bytes take part in compares
  localparam logic [KEY_W-1:0] KEY_MASK =
    (KEY_BYTES >= 8) ? {KEY_W{1'b1}} : ((64'd1 << (8 * KEY_BYTES)) - 64'd1);

  typedef enum logic [7:0] {
    S_IDLE    = 8'b0000_0001,
    S_INS     = 8'b0000_0010,
    S_INS_PUT = 8'b0000_0100,
    S_LIN     = 8'b0000_1000,
    S_BIN_RD  = 8'b0001_0000,
    S_BIN_CMP = 8'b0010_0000,
    S_LIST    = 8'b0100_0000,
    S_EMIT    = 8'b1000_0000
  } state_t;

  state_t            state_r, state_nxt;
  logic [CW-1:0]     count_r, count_nxt;
  logic [KEY_W-1:0]  key_r, key_nxt;
  logic [AW-1:0]     pos_r, pos_nxt;     // insert slot, scan index or probe
  logic [CW-1:0]     lo_r, lo_nxt;
  logic [CW-1:0]     hip_r, hip_nxt;     // binary search upper bound plus one

  // pending single result
  status_t           res_status_r, res_status_nxt;
  logic [AW-1:0]     res_index_r, res_index_nxt;
  logic [KEY_W-1:0]  res_key_r, res_key_nxt;

  // output register
  logic              out_valid_r, out_valid_nxt;
  logic [STATUS_W-1:0] out_status_r;
  logic [IDX_W-1:0]  out_index_r;
  logic [KEY_W-1:0]  out_key_r;
  logic              out_last_r;

  // output load request
  logic              out_free;
  logic              out_load;
  status_t           ld_status;
  logic [AW-1:0]     ld_index;
  logic [KEY_W-1:0]  ld_key;
  logic              ld_last;

  // key memory port
  logic              mem_we;
  logic [AW-1:0]     mem_waddr;
  logic [KEY_W-1:0]  mem_wdata;
  logic [AW-1:0]     mem_raddr;
  logic [KEY_W-1:0]  mem_rdata;

  logic              in_acc;
  logic [KEY_W-1:0]  in_key;
  logic [AW-1:0]     n_last;
  logic [CW:0]       probe_sum;
  logic [AW-1:0]     probe_mid;

  skts_key_mem #(
    .WORDS (WORDS),
    .AW    (AW)
  ) u_key_mem (
    .clk     (clk),
    .wr_en   (mem_we),
    .wr_addr (mem_waddr),
    .wr_data (mem_wdata),
    .rd_addr (mem_raddr),
    .rd_data (mem_rdata)
  );

  assign in_chan.ready = (state_r == S_IDLE);
  assign in_acc        = in_chan.valid && in_chan.ready;
  assign in_key        = in_chan.key & KEY_MASK;
  assign out_free      = !out_valid_r || out_chan.ready;

  // highest occupied position, only used while the table is not empty
  assign n_last    = AW'(count_r - CW'(1));
  // midpoint of lo .. hip-1, only used while lo < hip
  assign probe_sum = {1'b0, lo_r} + {1'b0, hip_r} - (CW+1)'(1);
  assign probe_mid = AW'(probe_sum >> 1);

  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    key_nxt        = key_r;
    pos_nxt        = pos_r;
    lo_nxt         = lo_r;
    hip_nxt        = hip_r;
    res_status_nxt = res_status_r;
    res_index_nxt  = res_index_r;
    res_key_nxt    = res_key_r;
    mem_we         = 1'b0;
    mem_waddr      = pos_r;
    mem_wdata      = key_r;
    mem_raddr      = pos_r;
    out_load       = 1'b0;
    ld_status      = res_status_r;
    ld_index       = res_index_r;
    ld_key         = res_key_r;
    ld_last        = 1'b1;

    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          key_nxt        = in_key;
          res_index_nxt  = '0;
          res_key_nxt    = '0;
          case (cmd_t'(in_chan.cmd))
            CMD_INSERT: begin
              if (count_r == CW'(TABLE_DEPTH)) begin
                res_status_nxt = ST_FULL;
                state_nxt      = S_EMIT;
              end else if (count_r == '0) begin
                // empty table: key goes straight to slot 0
                mem_we         = 1'b1;
                mem_waddr      = '0;
                mem_wdata      = in_key;
                count_nxt      = count_r + CW'(1);
                res_status_nxt = ST_DONE;
                res_key_nxt    = in_key;
                state_nxt      = S_EMIT;
              end else begin
                mem_raddr = n_last;
                pos_nxt   = AW'(count_r);
                state_nxt = S_INS;
              end
            end
            CMD_LIN_SEARCH: begin
              if (count_r == '0) begin
                res_status_nxt = ST_NOT_FOUND;
                state_nxt      = S_EMIT;
              end else begin
                mem_raddr = '0;
                pos_nxt   = '0;
                state_nxt = S_LIN;
              end
            end
            CMD_BIN_SEARCH: begin
              lo_nxt    = '0;
              hip_nxt   = count_r;
              state_nxt = S_BIN_RD;
            end
            CMD_LIST: begin
              if (count_r == '0) begin
                res_status_nxt = ST_EMPTY;
                state_nxt      = S_EMIT;
              end else begin
                mem_raddr = '0;
                pos_nxt   = '0;
                state_nxt = S_LIST;
              end
            end
            default: begin
              state_nxt = S_IDLE;
            end
          endcase
        end
      end

      // data holds entry pos-1; the read of pos-2 is issued ahead
      S_INS: begin
        mem_we    = 1'b1;
        mem_waddr = pos_r;
        if (mem_rdata > key_r) begin
          mem_wdata = mem_rdata;
          pos_nxt   = pos_r - AW'(1);
          mem_raddr = pos_r - AW'(2);
          if (pos_r == AW'(1)) begin
            state_nxt = S_INS_PUT;
          end
        end else begin
          mem_wdata      = key_r;
          count_nxt      = count_r + CW'(1);
          res_status_nxt = ST_DONE;
          res_index_nxt  = pos_r;
          res_key_nxt    = key_r;
          state_nxt      = S_EMIT;
        end
      end

      // every stored key was larger
      S_INS_PUT: begin
        mem_we         = 1'b1;
        mem_waddr      = '0;
        mem_wdata      = key_r;
        count_nxt      = count_r + CW'(1);
        res_status_nxt = ST_DONE;
        res_index_nxt  = '0;
        res_key_nxt    = key_r;
        state_nxt      = S_EMIT;
      end

      // data holds entry pos, next entry read ahead
      S_LIN: begin
        mem_raddr = pos_r + AW'(1);
        if (mem_rdata == key_r) begin
          res_status_nxt = ST_DONE;
          res_index_nxt  = pos_r;
          res_key_nxt    = mem_rdata;
          state_nxt      = S_EMIT;
        end else if (pos_r == n_last) begin
          res_status_nxt = ST_NOT_FOUND;
          state_nxt      = S_EMIT;
        end else begin
          pos_nxt = pos_r + AW'(1);
        end
      end

      S_BIN_RD: begin
        if (lo_r < hip_r) begin
          mem_raddr = probe_mid;
          pos_nxt   = probe_mid;
          state_nxt = S_BIN_CMP;
        end else begin
          res_status_nxt = ST_NOT_FOUND;
          state_nxt      = S_EMIT;
        end
      end

      S_BIN_CMP: begin
        if (mem_rdata > key_r) begin
          hip_nxt   = CW'(pos_r);
          state_nxt = S_BIN_RD;
        end else if (mem_rdata < key_r) begin
          lo_nxt    = CW'(pos_r) + CW'(1);
          state_nxt = S_BIN_RD;
        end else begin
          res_status_nxt = ST_DONE;
          res_index_nxt  = pos_r;
          res_key_nxt    = mem_rdata;
          state_nxt      = S_EMIT;
        end
      end

      // one entry per cycle; on a stall the same entry is read again
      S_LIST: begin
        mem_raddr = pos_r;
        if (out_free) begin
          out_load  = 1'b1;
          ld_status = ST_DONE;
          ld_index  = pos_r;
          ld_key    = mem_rdata;
          ld_last   = (pos_r == n_last);
          if (pos_r == n_last) begin
            state_nxt = S_IDLE;
          end else begin
            pos_nxt   = pos_r + AW'(1);
            mem_raddr = pos_r + AW'(1);
          end
        end
      end

      S_EMIT: begin
        if (out_free) begin
          out_load  = 1'b1;
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign out_valid_nxt = out_load || (out_valid_r && !out_chan.ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    key_r        <= key_nxt;
    pos_r        <= pos_nxt;
    lo_r         <= lo_nxt;
    hip_r        <= hip_nxt;
    res_status_r <= res_status_nxt;
    res_index_r  <= res_index_nxt;
    res_key_r    <= res_key_nxt;
    if (out_load) begin
      out_status_r <= ld_status;
      out_index_r  <= IDX_W'(ld_index);
      out_key_r    <= ld_key;
      out_last_r   <= ld_last;
    end
  end

  assign out_chan.valid     = out_valid_r;
  assign out_chan.status    = out_status_r;
  assign out_chan.index     = out_index_r;
  assign out_chan.entry_key = out_key_r;
  assign out_chan.last      = out_last_r;

  // checks
  `SKTS_ASSERT_IMP(a_count_bound, 1'b1, count_r <= CW'(TABLE_DEPTH),
    "entry count above table depth")
  `SKTS_ASSERT_IMP(a_count_step, $past(rst_n),
    (count_r == $past(count_r)) || (count_r == $past(count_r) + CW'(1)),
    "entry count moved by more than one")
  `SKTS_ASSERT_IMP(a_write_in_range, mem_we, CW'(mem_waddr) <= count_r,
    "key memory write beyond the occupied range")
  `SKTS_ASSERT_NXT(a_full_keeps_count, in_acc && (in_chan.cmd == CMD_INSERT) &&
    (count_r == CW'(TABLE_DEPTH)), count_r == CW'(TABLE_DEPTH),
    "insert into a full table changed the count")
endmodule

[bench/tb_top.sv]
// testbench for sorted_key_table_search: ordered insert, both searches and listing
// depends on skts_pkg, skts_in_if, skts_out_if and the block itself
`timescale 1ns / 100ps

module tb_top;
  import skts_pkg::*;

  localparam int TBL_DEPTH = DEF_TABLE_DEPTH;
  localparam int KEY_BYTES = DEF_KEY_BYTES;
  localparam logic [KEY_W-1:0] KEY_MASK =
    (KEY_BYTES >= 8) ? {KEY_W{1'b1}} : ((64'd1 << (8 * KEY_BYTES)) - 64'd1);
  // idle cycles allowed between any two accepted transfers; well above the
  // long receiver hold and the slowest request
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int HOLD_CYCLES    = 300;
  // quiet cycles at the end to catch results nobody asked for
  localparam int TAIL_CYCLES    = 100;

  // one expected result; a binary search on duplicate keys may land on any
  // of them, so the index is a range (lo == hi everywhere else)
  typedef struct {
    status_t          status;
    logic [IDX_W-1:0] idx_lo;
    logic [IDX_W-1:0] idx_hi;
    logic [KEY_W-1:0] entry_key;
    logic             last;
  } table_result_t;

  logic clk;
  logic rst_n;

  skts_in_if  in_chan();
  skts_out_if out_chan();

  sorted_key_table_search #(
    .TABLE_DEPTH (TBL_DEPTH),
    .KEY_BYTES   (KEY_BYTES)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  // shadow copy of the sorted table, updated when a request is accepted
  logic [KEY_W-1:0] key_tbl [TBL_DEPTH];
  int               key_cnt;
  table_result_t    pending_results[$];

  int err_cnt;
  int stall_cycles;
  int hold_cycles;   // set by a test, consumed by the receiver process
  bit in_idle_on;
  bit out_idle_on;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic void push_result(status_t st, int lo, int hi,
                                      logic [KEY_W-1:0] k, logic lst);
    table_result_t r;
    r.status    = st;
    r.idx_lo    = IDX_W'(lo);
    r.idx_hi    = IDX_W'(hi);
    r.entry_key = k;
    r.last      = lst;
    pending_results.push_back(r);
  endfunction

  // update the shadow table for one accepted request and queue its results
  function automatic void apply_request(cmd_t op, logic [KEY_W-1:0] raw_key);
    logic [KEY_W-1:0] k;
    int pos;
    int first_hit;
    int last_hit;
    k = raw_key & KEY_MASK;
    case (op)
      CMD_INSERT: begin
        if (key_cnt >= TBL_DEPTH) begin
          // full table drops the key
          push_result(ST_FULL, 0, 0, '0, 1'b1);
        end else begin
          // larger keys move up; equal keys stay below the new one
          pos = key_cnt;
          while (pos > 0 && key_tbl[pos-1] > k) begin
            key_tbl[pos] = key_tbl[pos-1];
            pos--;
          end
          key_tbl[pos] = k;
          key_cnt++;
          push_result(ST_DONE, pos, pos, k, 1'b1);
        end
      end
      CMD_LIN_SEARCH, CMD_BIN_SEARCH: begin
        first_hit = -1;
        last_hit  = -1;
        for (int i = 0; i < key_cnt; i++) begin
          if (key_tbl[i] == k) begin
            if (first_hit < 0) first_hit = i;
            last_hit = i;
          end
        end
        if (first_hit < 0) begin
          push_result(ST_NOT_FOUND, 0, 0, '0, 1'b1);
        end else if (op == CMD_LIN_SEARCH) begin
          push_result(ST_DONE, first_hit, first_hit, k, 1'b1);
        end else begin
          // equal keys sit next to each other, any of them is a valid hit
          push_result(ST_DONE, first_hit, last_hit, k, 1'b1);
        end
      end
      default: begin
        if (key_cnt == 0) begin
          push_result(ST_EMPTY, 0, 0, '0, 1'b1);
        end else begin
          for (int i = 0; i < key_cnt; i++)
            push_result(ST_DONE, i, i, key_tbl[i], (i == key_cnt - 1));
        end
      end
    endcase
  endfunction

  // four picks in ten take a stored key (hits and duplicates) or one above it
  // (near misses) while the table has keys, one in ten a short key, the rest fully random
  function automatic logic [KEY_W-1:0] pick_key();
    int sel;
    logic [KEY_W-1:0] k;
    sel = $urandom_range(0, 9);
    k   = {$urandom, $urandom};
    if (key_cnt > 0 && sel < 4) begin
      k = key_tbl[$urandom_range(0, key_cnt - 1)];
      if (sel == 3) k = k + 64'd1;
    end else if (sel == 4) begin
      k = {56'd0, k[7:0]};
    end
    return k;
  endfunction

  // offer one request and hold it until the block takes it
  task automatic send_request(cmd_t op, logic [KEY_W-1:0] k);
    if (in_idle_on && $urandom_range(0, 3) == 0) begin
      in_chan.valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    in_chan.valid <= 1'b1;
    in_chan.cmd   <= op;
    in_chan.key   <= k;
    do @(posedge clk); while (!in_chan.ready);
    apply_request(op, k);
  endtask

  task automatic send_random_request();
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 45)      send_request(CMD_INSERT, pick_key());
    else if (sel < 65) send_request(CMD_LIN_SEARCH, pick_key());
    else if (sel < 90) send_request(CMD_BIN_SEARCH, pick_key());
    else               send_request(CMD_LIST, pick_key());
  endtask

  // sender stops offering until every expected result is back
  task automatic wait_results_drained();
    in_chan.valid <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
  endtask

  // empty table: list reports empty, both searches miss
  task automatic test_empty_table();
    send_request(CMD_LIST, '0);
    send_request(CMD_LIN_SEARCH, '0);
    send_request(CMD_BIN_SEARCH, '1);
  endtask

  // extremes, a duplicate and keys landing at position 0 and at the top
  task automatic test_insert_order();
    send_request(CMD_INSERT, 64'h8000_0000_0000_0000);
    send_request(CMD_INSERT, '0);
    send_request(CMD_INSERT, '1);
    send_request(CMD_INSERT, 64'h0123_4567_89ab_cdef);
    send_request(CMD_INSERT, 64'h8000_0000_0000_0000);
    send_request(CMD_INSERT, 64'h7fff_ffff_ffff_ffff);
    send_request(CMD_INSERT, 64'd1);
  endtask

  // hits on duplicates, on both ends, and misses between stored keys
  task automatic test_searches();
    send_request(CMD_LIN_SEARCH, 64'h8000_0000_0000_0000);
    send_request(CMD_BIN_SEARCH, 64'h8000_0000_0000_0000);
    send_request(CMD_LIN_SEARCH, '0);
    send_request(CMD_BIN_SEARCH, '1);
    send_request(CMD_LIN_SEARCH, 64'h8000_0000_0000_0001);
    send_request(CMD_BIN_SEARCH, 64'h0123_4567_89ab_cdee);
    send_request(CMD_BIN_SEARCH, 64'd1);
    send_request(CMD_LIN_SEARCH, '1);
    send_request(CMD_LIST, '0);
  endtask

  task automatic test_random_mix(int n);
    repeat (n) send_random_request();
  endtask

  // fill to the last slot, then inserts that must be dropped
  task automatic test_fill_table();
    while (key_cnt < TBL_DEPTH) send_request(CMD_INSERT, pick_key());
    send_request(CMD_INSERT, '0);
    send_request(CMD_INSERT, '1);
    send_request(CMD_INSERT, pick_key());
    send_request(CMD_LIN_SEARCH, key_tbl[TBL_DEPTH-1]);
    send_request(CMD_BIN_SEARCH, key_tbl[0]);
  endtask

  // receiver holds off while a full-table list stalls behind the output
  task automatic test_output_backpressure();
    hold_cycles = HOLD_CYCLES;
    repeat (4) begin
      send_request(CMD_LIST, '0);
      send_request(CMD_BIN_SEARCH, pick_key());
    end
    wait_results_drained();
  endtask

  // closing stretch at full rate on both sides
  task automatic test_full_rate(int n);
    in_idle_on  = 1'b0;
    out_idle_on = 1'b0;
    repeat (n) send_random_request();
  endtask

  // receiver: random stall bursts, or one long hold when a test asks
  initial begin : result_sink
    int n;
    out_chan.ready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_cycles > 0) begin
        n = hold_cycles;
        hold_cycles = 0;
        out_chan.ready <= 1'b0;
        repeat (n) @(posedge clk);
      end else if (out_idle_on && $urandom_range(0, 3) == 0) begin
        out_chan.ready <= 1'b0;
        repeat ($urandom_range(1, 5)) @(posedge clk);
      end else begin
        out_chan.ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  // compare each accepted result with the oldest expectation
  always @(posedge clk) begin : result_check
    table_result_t want;
    if (rst_n && out_chan.valid && out_chan.ready) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result: status %0d index %0d entry_key %h last %0b",
               out_chan.status, out_chan.index, out_chan.entry_key, out_chan.last);
        err_cnt++;
      end else begin
        want = pending_results.pop_front();
        if (out_chan.status !== want.status) begin
          $error("status: expected %0d, actual %0d", want.status, out_chan.status);
          err_cnt++;
        end
        if ($isunknown(out_chan.index) || out_chan.index < want.idx_lo ||
            out_chan.index > want.idx_hi) begin
          $error("index: expected %0d..%0d, actual %0d",
                 want.idx_lo, want.idx_hi, out_chan.index);
          err_cnt++;
        end
        if (out_chan.entry_key !== want.entry_key) begin
          $error("entry_key: expected %h, actual %h", want.entry_key, out_chan.entry_key);
          err_cnt++;
        end
        if (out_chan.last !== want.last) begin
          $error("last: expected %0b, actual %0b", want.last, out_chan.last);
          err_cnt++;
        end
      end
    end
  end

  // watchdog: too long without any transfer on either channel
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_chan.valid && in_chan.ready) || (out_chan.valid && out_chan.ready))
        stall_cycles = 0;
      else
        stall_cycles++;
      if (stall_cycles >= WATCHDOG_LIMIT) begin
        $display("Mismatches found");
        $finish;
      end
    end
  end

  initial begin
    err_cnt      = 0;
    stall_cycles = 0;
    hold_cycles  = 0;
    key_cnt      = 0;
    in_idle_on   = 1'b1;
    out_idle_on  = 1'b1;
    rst_n         <= 1'b0;
    in_chan.valid <= 1'b0;
    in_chan.cmd   <= CMD_INSERT;
    in_chan.key   <= '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_empty_table();
    test_insert_order();
    test_searches();
    wait_results_drained();
    test_random_mix(60);
    test_fill_table();
    test_output_backpressure();
    test_full_rate(25);

    wait_results_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (err_cnt == 0 && pending_results.size() == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule

[sim.f]
+incdir+hw/rtl
hw/rtl/skts_pkg.sv
hw/rtl/skts_in_if.sv
hw/rtl/skts_out_if.sv
hw/rtl/skts_key_mem.sv
hw/rtl/sorted_key_table_search.sv
bench/tb_top.sv
